FILE: hw/rtl/integer_to_decimal_ascii_top_defines.svh
// assertion macros shared by the integer to decimal ascii rtl
`ifndef INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define I2DA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define I2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/i2da_pkg.sv
// types and constants for the integer to decimal ascii converter
package i2da_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

    // ceil(2^35 / 10), exact quotient for every 32-bit word
    localparam logic [WORD_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned       RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } i2da_state_t;

    typedef struct packed {
        logic start;
        logic step;
    } i2da_ctl_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               quot_zero;
    } i2da_stat_t;

endpackage

FILE: hw/rtl/i2da_div10.sv
// shared divide-by-ten unit: reciprocal multiply, one digit per step
module i2da_div10 (
    input  logic                          clk,
    input  i2da_pkg::i2da_ctl_t           ctl,
    input  logic [i2da_pkg::WORD_W-1:0]   mag_in,
    output i2da_pkg::i2da_stat_t          stat
);
    import i2da_pkg::*;

    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;

    logic [WORD_W-1:0] mag_reg;
    logic [WORD_W-1:0] mag_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] quot_x10;
    logic [WORD_W-1:0] rem;

    // quotient of the held magnitude, taken from the registered product
    assign quot     = {{(WORD_W-QUOT_W){1'b0}}, prod_reg[PROD_W-1:RECIP_SHIFT]};
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = mag_reg - quot_x10;

    assign stat.digit     = rem[DIGIT_W-1:0];
    assign stat.quot_zero = (quot == '0);

    always_comb
    begin
        mag_next  = mag_reg;
        prod_next = prod_reg;
        if (ctl.start)
        begin
            mag_next  = mag_in;
            prod_next = PROD_W'(mag_in) * PROD_W'(RECIP_TEN);
        end
        else if (ctl.step)
        begin
            mag_next  = quot;
            prod_next = PROD_W'(quot) * PROD_W'(RECIP_TEN);
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
    end

endmodule

FILE: hw/rtl/integer_to_decimal_ascii_top.sv
// top level: 32-bit word to decimal ascii characters, one per transaction
// sequence: accept edge, then one decimal digit (1 to 10) per cycle in the
//   divide-by-ten unit, then the first character is registered out in the emit state
// input: in_stall holds off a new number until the sequencer is back in idle;
//   the reciprocal multiply in the divide-by-ten unit paces the digit loop
// reset: rst_n asynchronous active low, clears the sequencer and output valid
module integer_to_decimal_ascii_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [i2da_pkg::WORD_W-1:0]    value_bits,
    input  logic                           func,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [i2da_pkg::CHAR_W-1:0]    out_char,
    output logic                           is_last,
    output logic [i2da_pkg::COUNT_W-1:0]   char_count
);
    import i2da_pkg::*;

`include "integer_to_decimal_ascii_top_defines.svh"

    i2da_state_t state_reg, state_next;

    i2da_ctl_t  ctl;
    i2da_stat_t stat;

    logic                 in_accept;
    logic                 negative;
    logic [WORD_W-1:0]    magnitude;

    logic                 neg_reg, neg_next;
    logic [IDX_W-1:0]     nd_reg, nd_next;      // digits produced so far
    logic [IDX_W-1:0]     idx_reg, idx_next;    // digit being sent
    logic [COUNT_W-1:0]   count_reg, count_next;

    // digit store, least significant digit at index zero
    logic [DIGIT_W-1:0]   digit_mem [MAX_DIGITS];
    // digit at idx_reg, registered from the store at idx_next
    logic [DIGIT_W-1:0]   digit_rd_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 is_last_reg, is_last_next;
    logic [COUNT_W-1:0]   char_count_reg, char_count_next;
    logic                 out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // signed mode with bit 31 set: magnitude is the two's complement,
    // the most negative word comes out as 2^31 which still fits
    assign negative  = !func && value_bits[WORD_W-1];
    assign magnitude = negative ? (~value_bits + WORD_W'(1)) : value_bits;

    assign out_free  = !out_valid_reg || !out_stall;

    i2da_div10 u_div10 (
        .clk    (clk),
        .ctl    (ctl),
        .mag_in (magnitude),
        .stat   (stat)
    );

    // sequencer: idle -> conv (one digit per cycle) -> emit (one char per transaction)
    always_comb
    begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        nd_next         = nd_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        ctl.start       = 1'b0;
        ctl.step        = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        out_char_next   = out_char_reg;
        is_last_next    = is_last_reg;
        char_count_next = char_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ctl.start  = 1'b1;
                    neg_next   = negative;
                    nd_next    = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.step = 1'b1;
                nd_next  = nd_reg + IDX_W'(1);
                if (stat.quot_zero)
                begin
                    // top digit found, start sending from it
                    idx_next   = nd_reg;
                    count_next = COUNT_W'(nd_reg) + COUNT_W'(1) + COUNT_W'(neg_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        out_char_next   = ASCII_MINUS;
                        is_last_next    = 1'b0;
                        char_count_next = '0;
                        neg_next        = 1'b0;
                    end
                    else
                    begin
                        out_char_next = ASCII_ZERO + CHAR_W'(digit_rd_reg);
                        if (idx_reg == '0)
                        begin
                            is_last_next    = 1'b1;
                            char_count_next = count_reg;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            is_last_next    = 1'b0;
                            char_count_next = '0;
                            idx_next        = idx_reg - IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        nd_reg         <= nd_next;
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        out_char_reg   <= out_char_next;
        is_last_reg    <= is_last_next;
        char_count_reg <= char_count_next;
    end

    // digit store written at the running digit count, read at the next
    // send index; the top digit bypasses the store as it is written
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            digit_mem[nd_reg] <= stat.digit;
        end
        if (ctl.step && (nd_reg == idx_next))
        begin
            digit_rd_reg <= stat.digit;
        end
        else
        begin
            digit_rd_reg <= digit_mem[idx_next];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign is_last    = is_last_reg;
    assign char_count = char_count_reg;

    // a 32-bit magnitude never needs more than ten digit steps
    `I2DA_ASSERT_NOW(a_digit_bound, state_reg == ST_CONV, nd_reg < IDX_W'(MAX_DIGITS), "digit count overrun")
    // the final character always carries a nonzero count
    `I2DA_ASSERT_NOW(a_last_count, out_valid_reg && is_last_reg, char_count_reg != '0, "last char without count")
    // after a non-final character is taken, the next one is ready at once
    `I2DA_ASSERT_NEXT(a_no_gap, out_valid_reg && !out_stall && !is_last_reg, out_valid_reg, "gap inside a number")
    // an accepted transaction always starts the digit loop
    `I2DA_ASSERT_NEXT(a_start_conv, in_accept, state_reg == ST_CONV, "accept did not start conversion")

endmodule
